// ----- rtl/trpc_pkg.sv -----
// ----------------------------------------------------------------------------
// trpc_pkg: shared constants for the timer prescaler and reload calculator
// Field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package trpc_pkg;

    localparam int CLK_W   = 28;
    localparam int FREQ_W  = 20;
    localparam int REQ_W   = 32;
    localparam int VAL_W   = 16;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 32;
    // Period >> 16 of a period below 2**CLK_W.
    localparam int PSC_W   = CLK_W - VAL_W;
    localparam int DIV_W   = PSC_W + 1;

    localparam logic [IDX_W-1:0] REG_SLOW_CLK = 8'd0;
    localparam logic [IDX_W-1:0] REG_FAST_CLK = 8'd1;
    localparam logic [IDX_W-1:0] REG_MIN_FREQ = 8'd2;
    localparam logic [IDX_W-1:0] REG_MAX_FREQ = 8'd3;

    localparam logic [CLK_W-1:0]  SLOW_CLK_RST = 28'd84000000;
    localparam logic [CLK_W-1:0]  FAST_CLK_RST = 28'd168000000;
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 20'd100;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 20'd50000;

endpackage

// ----- rtl/trpc_div.sv -----
// ----------------------------------------------------------------------------
// trpc_div: pipelined restoring divider
// One quotient bit per stage, with a side word and a valid bit per stage.
// ----------------------------------------------------------------------------
module trpc_div #(
    parameter int N_W = 28,
    parameter int D_W = 20,
    parameter int S_W = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    input  logic [S_W-1:0] side_in,
    output logic           out_vld,
    output logic [N_W-1:0] quo,
    output logic [S_W-1:0] side_out
);

    logic [N_W-1:0] num_reg  [N_W+1];
    logic [D_W-1:0] rem_reg  [N_W+1];
    logic [D_W-1:0] den_reg  [N_W+1];
    logic [S_W-1:0] side_reg [N_W+1];
    logic           vld_reg  [N_W+1];

    always_comb
    begin
        num_reg[0]  = num;
        rem_reg[0]  = '0;
        den_reg[0]  = den;
        side_reg[0] = side_in;
        vld_reg[0]  = in_vld;
    end

    for (genvar s = 0; s < N_W; s++) begin : g_stage
        logic [D_W:0] shifted;
        logic         ge;
        logic [D_W:0] diff;
        logic [D_W-1:0] rem_next;
        logic [N_W-1:0] num_next;

        always_comb
        begin
            shifted  = {rem_reg[s], num_reg[s][N_W-1]};
            ge       = shifted >= {1'b0, den_reg[s]};
            diff     = shifted - {1'b0, den_reg[s]};
            // When the trial fails the shifted remainder is below the divisor.
            rem_next = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
            num_next = {num_reg[s][N_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[s+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv) begin
                num_reg[s+1]  <= num_next;
                rem_reg[s+1]  <= rem_next;
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_vld  = vld_reg[N_W];
    assign quo      = num_reg[N_W];
    assign side_out = side_reg[N_W];

endmodule

// ----- rtl/timer_prescaler_reload_calc.sv -----
// ----------------------------------------------------------------------------
// timer_prescaler_reload_calc: prescaler and auto-reload from a frequency
// Clamps the request, divides the bus clock by it, then splits the period.
// ----------------------------------------------------------------------------
// Pipeline stages in order: clamp stage, 28 divider stages, prescaler stage,
// 28 divider stages and the output stage.
// Throughput: one request per cycle; each divider stage retires one quotient
// bit. The whole pipe holds while a finished result waits to be taken.
// Reset: all valid bits clear and the configuration registers take their default values.
module timer_prescaler_reload_calc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [trpc_pkg::REQ_W-1:0] requested_hz,
    input  logic                       on_fast_bus,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [trpc_pkg::VAL_W-1:0] prescaler,
    output logic [trpc_pkg::VAL_W-1:0] reload,
    output logic                       no_fit,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [trpc_pkg::IDX_W-1:0] cfg_index,
    input  logic [trpc_pkg::DATA_W-1:0] cfg_data
);

    localparam int CLK_W  = trpc_pkg::CLK_W;
    localparam int FREQ_W = trpc_pkg::FREQ_W;
    localparam int VAL_W  = trpc_pkg::VAL_W;
    localparam int PSC_W  = trpc_pkg::PSC_W;
    localparam int DIV_W  = trpc_pkg::DIV_W;

    // Configuration registers; writes are always taken.
    logic [CLK_W-1:0]  slow_clk_reg;
    logic [CLK_W-1:0]  fast_clk_reg;
    logic [FREQ_W-1:0] min_freq_reg;
    logic [FREQ_W-1:0] max_freq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slow_clk_reg <= trpc_pkg::SLOW_CLK_RST;
            fast_clk_reg <= trpc_pkg::FAST_CLK_RST;
            min_freq_reg <= trpc_pkg::MIN_FREQ_RST;
            max_freq_reg <= trpc_pkg::MAX_FREQ_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                trpc_pkg::REG_SLOW_CLK: slow_clk_reg <= cfg_data[CLK_W-1:0];
                trpc_pkg::REG_FAST_CLK: fast_clk_reg <= cfg_data[CLK_W-1:0];
                trpc_pkg::REG_MIN_FREQ: min_freq_reg <= cfg_data[FREQ_W-1:0];
                trpc_pkg::REG_MAX_FREQ: max_freq_reg <= cfg_data[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as a whole whenever the output register is free.
    logic adv;
    logic out_vld_reg;
    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    // Clamp stage: the upper clamp is applied last, so it wins when the
    // minimum lies above the maximum.
    logic [trpc_pkg::REQ_W-1:0] lo_clamped;
    logic [FREQ_W-1:0]          freq_next;
    logic [FREQ_W-1:0]          freq_reg;
    logic [CLK_W-1:0]           clk_sel_reg;
    logic                       clamp_vld_reg;

    always_comb
    begin
        lo_clamped = (requested_hz < {12'd0, min_freq_reg}) ?
                     {12'd0, min_freq_reg} : requested_hz;
        freq_next  = (lo_clamped > {12'd0, max_freq_reg}) ?
                     max_freq_reg : lo_clamped[FREQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clamp_vld_reg <= 1'b0;
        end else if (adv) begin
            clamp_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            freq_reg    <= freq_next;
            clk_sel_reg <= on_fast_bus ? fast_clk_reg : slow_clk_reg;
        end
    end

    // Period = bus clock / frequency. A zero frequency is carried as a flag
    // and forces no_fit at the end.
    logic             per_vld;
    logic [CLK_W-1:0] period;
    logic             freq_zero;

    trpc_div #(
        .N_W(CLK_W),
        .D_W(FREQ_W),
        .S_W(1)
    ) u_period_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (clamp_vld_reg),
        .num     (clk_sel_reg),
        .den     (freq_reg),
        .side_in (freq_reg == '0),
        .out_vld (per_vld),
        .quo     (period),
        .side_out(freq_zero)
    );

    // Prescaler stage: the smallest divisor is (period >> 16) + 1. It never
    // exceeds the period once the period is nonzero, so the period and the
    // zero-frequency flag alone decide whether a fit exists.
    logic             psc_vld_reg;
    logic [CLK_W-1:0] period_reg;
    logic [PSC_W-1:0] psc_reg;
    logic             fit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            psc_vld_reg <= 1'b0;
        end else if (adv) begin
            psc_vld_reg <= per_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            period_reg <= period;
            psc_reg    <= period[CLK_W-1:VAL_W];
            fit_reg    <= !freq_zero && (period != '0);
        end
    end

    // Reload quotient = period / (prescaler + 1), which stays below 2**16.
    logic             quo_vld;
    logic [CLK_W-1:0] arr_quo;
    logic [PSC_W:0]   side_q;

    trpc_div #(
        .N_W(CLK_W),
        .D_W(DIV_W),
        .S_W(PSC_W + 1)
    ) u_reload_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (psc_vld_reg),
        .num     (period_reg),
        .den     ({1'b0, psc_reg} + DIV_W'(1)),
        .side_in ({fit_reg, psc_reg}),
        .out_vld (quo_vld),
        .quo     (arr_quo),
        .side_out(side_q)
    );

    // Output register; values are zero when nothing fits.
    logic [VAL_W-1:0] psc_out_reg;
    logic [VAL_W-1:0] arr_out_reg;
    logic             no_fit_reg;
    logic [VAL_W-1:0] arr_next;

    assign arr_next = arr_quo[VAL_W-1:0] - VAL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= quo_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            psc_out_reg <= side_q[PSC_W] ? {{(VAL_W-PSC_W){1'b0}}, side_q[PSC_W-1:0]} : '0;
            arr_out_reg <= side_q[PSC_W] ? arr_next : '0;
            no_fit_reg  <= !side_q[PSC_W];
        end
    end

    assign out_valid = out_vld_reg;
    assign prescaler = psc_out_reg;
    assign reload    = arr_out_reg;
    assign no_fit    = no_fit_reg;

endmodule

// ----- bench/trpc_checker.sv -----
// ----------------------------------------------------------------------------
// trpc_checker: result predictor and scoreboard for the prescaler calculator
// Watches the request, result and register channels, computes the expected
// prescaler and reload for every request and compares them in order.
// ----------------------------------------------------------------------------
module trpc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [trpc_pkg::REQ_W-1:0] requested_hz,
    input  logic                       on_fast_bus,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [trpc_pkg::VAL_W-1:0] prescaler,
    input  logic [trpc_pkg::VAL_W-1:0] reload,
    input  logic                       no_fit,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [trpc_pkg::IDX_W-1:0] cfg_index,
    input  logic [trpc_pkg::DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [trpc_pkg::VAL_W-1:0] psc;
        logic [trpc_pkg::VAL_W-1:0] arr;
        logic                       nofit;
    } timing_t;

    logic [trpc_pkg::CLK_W-1:0]  slow_clk_hz;
    logic [trpc_pkg::CLK_W-1:0]  fast_clk_hz;
    logic [trpc_pkg::FREQ_W-1:0] min_hz;
    logic [trpc_pkg::FREQ_W-1:0] max_hz;
    timing_t                     timing_q[$];

    function automatic timing_t compute_timing(logic [trpc_pkg::REQ_W-1:0] req, logic fast);
        logic [trpc_pkg::REQ_W-1:0] freq;
        logic [31:0]                bus_hz;
        logic [31:0]                ticks;
        logic [31:0]                divisor;
        timing_t                    t;
        t = '{psc: '0, arr: '0, nofit: 1'b1};
        bus_hz = fast ? 32'(fast_clk_hz) : 32'(slow_clk_hz);
        freq = req;
        if (freq < trpc_pkg::REQ_W'(min_hz))
            freq = trpc_pkg::REQ_W'(min_hz);
        if (freq > trpc_pkg::REQ_W'(max_hz))
            freq = trpc_pkg::REQ_W'(max_hz);
        if (freq != 0)
        begin
            ticks = bus_hz / freq;
            divisor = (ticks >> 16) + 1;
            if (ticks >= 1 && divisor <= ticks && divisor <= 32'hFFFF)
            begin
                t.psc = trpc_pkg::VAL_W'(divisor - 1);
                t.arr = trpc_pkg::VAL_W'(ticks / divisor - 1);
                t.nofit = 1'b0;
            end
        end
        return t;
    endfunction

    assign pending = timing_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        timing_t want;
        if (!rst_n)
        begin
            slow_clk_hz <= trpc_pkg::SLOW_CLK_RST;
            fast_clk_hz <= trpc_pkg::FAST_CLK_RST;
            min_hz <= trpc_pkg::MIN_FREQ_RST;
            max_hz <= trpc_pkg::MAX_FREQ_RST;
            timing_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                timing_q.push_back(compute_timing(requested_hz, on_fast_bus));
            if (out_valid && out_ready)
            begin
                if (timing_q.size() == 0)
                begin
                    $display("%0t: result with none expected: psc %0d arr %0d nofit %0b",
                             $time, prescaler, reload, no_fit);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = timing_q.pop_front();
                    if (want.psc !== prescaler || want.arr !== reload
                        || want.nofit !== no_fit)
                    begin
                        $display("%0t: mismatch expected psc %0d arr %0d nofit %0b, got %0d %0d %0b",
                                 $time, want.psc, want.arr, want.nofit,
                                 prescaler, reload, no_fit);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    trpc_pkg::REG_SLOW_CLK: slow_clk_hz <= cfg_data[trpc_pkg::CLK_W-1:0];
                    trpc_pkg::REG_FAST_CLK: fast_clk_hz <= cfg_data[trpc_pkg::CLK_W-1:0];
                    trpc_pkg::REG_MIN_FREQ: min_hz <= cfg_data[trpc_pkg::FREQ_W-1:0];
                    trpc_pkg::REG_MAX_FREQ: max_hz <= cfg_data[trpc_pkg::FREQ_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- bench/tb_timer_prescaler_reload_calc.sv -----
// ----------------------------------------------------------------------------
// tb_timer_prescaler_reload_calc: testbench for the prescaler calculator
// Drives directed and random frequency requests under several register
// settings and idle patterns; a checker alongside the block scores results.
// ----------------------------------------------------------------------------
module tb_timer_prescaler_reload_calc;

    // Drain waits use a margin above the depth of the block's pipe.
    localparam int PIPE_DRAIN = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [trpc_pkg::REQ_W-1:0]  requested_hz = '0;
    logic                        on_fast_bus = 1'b0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [trpc_pkg::VAL_W-1:0]  prescaler;
    logic [trpc_pkg::VAL_W-1:0]  reload;
    logic                        no_fit;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [trpc_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [trpc_pkg::DATA_W-1:0] cfg_data = '0;
    int                          fail_count;
    int                          pending;
    int                          cycle_count = 0;
    // Percent chances of the sender idling and the receiver stalling.
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    // While set, the receiver holds off entirely so the pipe backs up.
    logic                        hold_off = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    timer_prescaler_reload_calc dut (.*);

    trpc_checker checker_i (.*);

    // The receiver decides its ready every cycle on its own.
    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_timer_prescaler_reload_calc: errors");
            $finish;
        end
    end

    // One request transfer; valid stays up through back-to-back requests and
    // only drops when the sender chooses to idle.
    task automatic send_request(logic [trpc_pkg::REQ_W-1:0] hz, logic fast);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        requested_hz <= hz;
        on_fast_bus <= fast;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every result is back, then let the pipe settle.
    task automatic drain();
        drop_valid();
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [trpc_pkg::IDX_W-1:0] idx,
                             logic [trpc_pkg::DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(int slow, int fast, int lo, int hi);
        write_reg(trpc_pkg::REG_SLOW_CLK, trpc_pkg::DATA_W'(slow));
        write_reg(trpc_pkg::REG_FAST_CLK, trpc_pkg::DATA_W'(fast));
        write_reg(trpc_pkg::REG_MIN_FREQ, trpc_pkg::DATA_W'(lo));
        write_reg(trpc_pkg::REG_MAX_FREQ, trpc_pkg::DATA_W'(hi));
    endtask

    // Requests are mostly near the clamp window, with some full-range values
    // so every bit of the request field toggles.
    function automatic logic [trpc_pkg::REQ_W-1:0] pick_hz();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(200);
            default: return $urandom_range(1100000);
        endcase
    endfunction

    task automatic random_burst(int count);
        repeat (count)
            send_request(pick_hz(), 1'($urandom));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at reset values: extremes and both buses.
        send_request('0, 1'b0);
        send_request('1, 1'b1);
        send_request(32'd100, 1'b0);
        send_request(32'd50000, 1'b1);
        send_request(32'd1000, 1'b1);
        send_request(32'h8000_0000, 1'b0);
        drain();

        // Minimum above maximum: the upper clamp wins.
        set_regs(200000000, 1, 1000000, 10);
        send_request(32'd5, 1'b0);
        send_request(32'd5, 1'b1);
        drain();

        // Both clamps zero: the clamped frequency is zero.
        set_regs(84000000, 168000000, 0, 0);
        send_request(32'd7, 1'b0);
        send_request(32'd0, 1'b1);
        drain();

        // Zero bus clock and a clock below the frequency give a zero period.
        set_regs(0, 50, 1, 1000000);
        send_request(32'd100, 1'b0);
        send_request(32'd100, 1'b1);
        send_request(32'd1, 1'b1);
        send_request(32'd1, 1'b0);
        // Index beyond the register map is ignored.
        drain();
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(8'd4, 32'd1);
        send_request(32'd25, 1'b1);
        drain();

        // Largest clocks with the lowest clamp give the largest prescaler.
        set_regs(32'hFFFF_FFFF, 200000000, 1, 1);
        send_request(32'd0, 1'b0);
        send_request(32'd0, 1'b1);
        drain();

        // Random phases under varied settings and idle patterns.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            case (phase)
                0: set_regs(84000000, 168000000, 100, 50000);
                1: set_regs(1, 200000000, 1, 1000000);
                2: set_regs(200000000, 1, 1000000, 1);
                3: set_regs($urandom_range(200000000, 1), $urandom_range(200000000, 1),
                            $urandom_range(100), $urandom_range(1000000));
                4: set_regs($urandom, $urandom, $urandom, $urandom);
                default: set_regs($urandom_range(200000000, 1),
                                  $urandom_range(200000000, 1),
                                  $urandom_range(1000), $urandom_range(1000000, 1));
            endcase
            random_burst(200);
            // Long receiver hold-off while requests keep coming, so the pipe
            // fills and input ready drops.
            if (phase == 2)
            begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                    random_burst(100);
                join
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        if (fail_count == 0)
            $display("tb_timer_prescaler_reload_calc: clean");
        else
            $display("tb_timer_prescaler_reload_calc: errors");
        $finish;
    end

endmodule
